// ===== src/swhsr_pkg.sv =====
// ----------------------------------------------------------------------------
// swhsr_pkg
// Types and constants of the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhsr_pkg;

  localparam int unsigned FrameBits = 40;
  localparam int unsigned TickW     = 16;
  localparam int unsigned BitIdxW   = 6;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  localparam logic [15:0] StartLowReset    = 16'd2000;
  localparam logic [7:0]  ReleaseHighReset = 8'd60;
  localparam logic [7:0]  OneThreshReset   = 8'd96;

  typedef enum logic [1:0] {
    CfgStartLow    = 2'd0,
    CfgReleaseHigh = 2'd1,
    CfgOneThresh   = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PhIdle     = 4'd0,
    PhStartLow = 4'd1,
    PhDrvHigh  = 4'd2,
    PhWaitResp = 4'd3,
    PhRespLow  = 4'd4,
    PhRespHigh = 4'd5,
    PhBitLow   = 4'd6,
    PhBitHigh  = 4'd7
  } phase_e;

  typedef struct packed {
    logic start_request;
    logic line_in;
  } in_word_t;

  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] humidity;
    logic [15:0] temperature;
    logic        checksum_ok;
  } out_word_t;

endpackage

// ===== src/swhsr_if.sv =====
// ----------------------------------------------------------------------------
// swhsr_if
// Valid/ready channels that carry tick words in and result words out.
// ----------------------------------------------------------------------------
interface swhsr_in_if;
  logic               valid;
  logic               ready;
  swhsr_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swhsr_out_if;
  logic                valid;
  logic                ready;
  swhsr_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/single_wire_humidity_sensor_reader.sv =====
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader
// Host side of a single-wire humidity and temperature sensor link.
// ----------------------------------------------------------------------------
// Each input word is one sampling tick of the data line and is accepted in
// any cycle in which the output register is empty or being emptied, so the
// block sustains one tick per clock. Its result word appears in the output
// register on the next cycle; a stalled output holds the input back only
// while that single register stays full. On a start request the block drives
// the line low, then high, releases it, skips the sensor response and times
// forty high pulses, MSB first, before latching humidity, temperature and the
// checksum flag. There are no timeouts.
module single_wire_humidity_sensor_reader (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  swhsr_in_if.sink          in_i,
  swhsr_out_if.source       out_o
);

  logic [15:0] start_low_q;
  logic [7:0]  release_high_q;
  logic [7:0]  one_thresh_q;

  swhsr_pkg::phase_e                   phase_q, phase_d;
  logic [swhsr_pkg::TickW-1:0]         tick_q, tick_d;
  logic [swhsr_pkg::BitIdxW-1:0]       bit_idx_q, bit_idx_d;
  logic [swhsr_pkg::FrameBits-1:0]     frame_q, frame_d;
  logic [15:0]                         hum_q, hum_d;
  logic [15:0]                         temp_q, temp_d;
  logic                                csum_ok_q, csum_ok_d;
  logic                                done;
  logic [7:0]                          byte_sum;

  logic                 out_valid_q;
  swhsr_pkg::out_word_t out_q, out_d;
  logic                 accept;

  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign accept      = in_i.valid & in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q    <= swhsr_pkg::StartLowReset;
      release_high_q <= swhsr_pkg::ReleaseHighReset;
      one_thresh_q   <= swhsr_pkg::OneThreshReset;
    end else if (cfg_we_i) begin
      unique case (swhsr_pkg::cfg_idx_e'(cfg_idx_i))
        swhsr_pkg::CfgStartLow:    start_low_q    <= cfg_data_i;
        swhsr_pkg::CfgReleaseHigh: release_high_q <= cfg_data_i[7:0];
        swhsr_pkg::CfgOneThresh:   one_thresh_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_idx_d = bit_idx_q;
    frame_d   = frame_q;
    hum_d     = hum_q;
    temp_d    = temp_q;
    csum_ok_d = csum_ok_q;
    done      = 1'b0;
    byte_sum  = 8'd0;

    unique case (phase_q)
      swhsr_pkg::PhIdle: begin
        if (in_i.data.start_request) begin
          phase_d   = swhsr_pkg::PhStartLow;
          tick_d    = swhsr_pkg::TickW'(1);
          bit_idx_d = '0;
          frame_d   = '0;
        end
      end
      swhsr_pkg::PhStartLow: begin
        if (tick_q >= start_low_q) begin
          phase_d = swhsr_pkg::PhDrvHigh;
          tick_d  = swhsr_pkg::TickW'(1);
        end else begin
          tick_d = tick_q + 1'b1;
        end
      end
      swhsr_pkg::PhDrvHigh: begin
        if (tick_q >= {8'd0, release_high_q}) begin
          phase_d = swhsr_pkg::PhWaitResp;
          tick_d  = '0;
        end else begin
          tick_d = tick_q + 1'b1;
        end
      end
      swhsr_pkg::PhWaitResp: begin
        if (!in_i.data.line_in) phase_d = swhsr_pkg::PhRespLow;
      end
      swhsr_pkg::PhRespLow: begin
        if (in_i.data.line_in) phase_d = swhsr_pkg::PhRespHigh;
      end
      swhsr_pkg::PhRespHigh: begin
        if (!in_i.data.line_in) phase_d = swhsr_pkg::PhBitLow;
      end
      swhsr_pkg::PhBitLow: begin
        if (in_i.data.line_in) begin
          phase_d = swhsr_pkg::PhBitHigh;
          tick_d  = swhsr_pkg::TickW'(1);
        end
      end
      swhsr_pkg::PhBitHigh: begin
        if (in_i.data.line_in) begin
          if (tick_q != swhsr_pkg::TickMax) tick_d = tick_q + 1'b1;
        end else begin
          frame_d   = {frame_q[swhsr_pkg::FrameBits-2:0], (tick_q > {8'd0, one_thresh_q})};
          bit_idx_d = bit_idx_q + 1'b1;
          tick_d    = '0;
          if (bit_idx_d >= swhsr_pkg::BitIdxW'(swhsr_pkg::FrameBits)) begin
            byte_sum  = frame_d[39:32] + frame_d[31:24] + frame_d[23:16] + frame_d[15:8];
            hum_d     = frame_d[39:24];
            temp_d    = frame_d[23:8];
            csum_ok_d = (byte_sum == frame_d[7:0]);
            done      = 1'b1;
            phase_d   = swhsr_pkg::PhIdle;
          end else begin
            phase_d = swhsr_pkg::PhBitLow;
          end
        end
      end
      default: phase_d = swhsr_pkg::PhIdle;
    endcase

    out_d.drive_enable = (phase_d == swhsr_pkg::PhStartLow) ||
                         (phase_d == swhsr_pkg::PhDrvHigh);
    out_d.drive_level  = (phase_d == swhsr_pkg::PhDrvHigh);
    out_d.busy_res     = (phase_d != swhsr_pkg::PhIdle);
    out_d.done_res     = done;
    out_d.humidity     = hum_d;
    out_d.temperature  = temp_d;
    out_d.checksum_ok  = csum_ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= swhsr_pkg::PhIdle;
      tick_q      <= '0;
      bit_idx_q   <= '0;
      frame_q     <= '0;
      hum_q       <= '0;
      temp_q      <= '0;
      csum_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        bit_idx_q   <= bit_idx_d;
        frame_q     <= frame_d;
        hum_q       <= hum_d;
        temp_q      <= temp_d;
        csum_ok_q   <= csum_ok_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word left no result");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while result register is stalled");

  a_level_needs_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.drive_level) |-> out_q.drive_enable)
    else $error("drive level high with line released");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> (!out_q.busy_res && phase_q == swhsr_pkg::PhIdle))
    else $error("frame finished while still busy");

  a_bit_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= swhsr_pkg::BitIdxW'(swhsr_pkg::FrameBits))
    else $error("bit index ran past the frame");

endmodule

// ===== test/swhsr_reading_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swhsr_reading_checker
// Watches the tick and result channels and the register port of the sensor
// reader, predicts every result word from the accepted tick words and checks
// the words that leave the block, field by field and in order.
// ----------------------------------------------------------------------------
module swhsr_reading_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  swhsr_in_if         tick_mon,
  swhsr_out_if        result_mon,
  output int          mismatch_cnt_o,
  output int          outstanding_o
);

  logic [15:0] low_ticks;
  logic [7:0]  high_ticks;
  logic [7:0]  one_thresh;

  swhsr_pkg::phase_e link_phase;
  logic [15:0]       pulse_ticks;
  logic [5:0]        bits_taken;
  logic [39:0]       frame_bits;
  logic [15:0]       humidity_q;
  logic [15:0]       temperature_q;
  logic              checksum_ok_q;

  swhsr_pkg::out_word_t readouts_due[$];

  task automatic advance_link(input swhsr_pkg::in_word_t tick,
                              output swhsr_pkg::out_word_t res);
    logic       done;
    logic [7:0] byte_sum;
    done = 1'b0;
    case (link_phase)
      swhsr_pkg::PhIdle: begin
        if (tick.start_request) begin
          link_phase  = swhsr_pkg::PhStartLow;
          pulse_ticks = 16'd1;
          bits_taken  = '0;
          frame_bits  = '0;
        end
      end
      swhsr_pkg::PhStartLow: begin
        if (pulse_ticks >= low_ticks) begin
          link_phase  = swhsr_pkg::PhDrvHigh;
          pulse_ticks = 16'd1;
        end else begin
          pulse_ticks = pulse_ticks + 16'd1;
        end
      end
      swhsr_pkg::PhDrvHigh: begin
        if (pulse_ticks >= {8'h00, high_ticks}) begin
          link_phase  = swhsr_pkg::PhWaitResp;
          pulse_ticks = '0;
        end else begin
          pulse_ticks = pulse_ticks + 16'd1;
        end
      end
      swhsr_pkg::PhWaitResp: if (!tick.line_in) link_phase = swhsr_pkg::PhRespLow;
      swhsr_pkg::PhRespLow:  if (tick.line_in) link_phase = swhsr_pkg::PhRespHigh;
      swhsr_pkg::PhRespHigh: if (!tick.line_in) link_phase = swhsr_pkg::PhBitLow;
      swhsr_pkg::PhBitLow: begin
        if (tick.line_in) begin
          link_phase  = swhsr_pkg::PhBitHigh;
          pulse_ticks = 16'd1;
        end
      end
      swhsr_pkg::PhBitHigh: begin
        if (tick.line_in) begin
          if (pulse_ticks != swhsr_pkg::TickMax) pulse_ticks = pulse_ticks + 16'd1;
        end else begin
          frame_bits  = {frame_bits[38:0], pulse_ticks > {8'h00, one_thresh}};
          bits_taken  = bits_taken + 6'd1;
          pulse_ticks = '0;
          if (bits_taken >= swhsr_pkg::FrameBits) begin
            humidity_q    = frame_bits[39:24];
            temperature_q = frame_bits[23:8];
            byte_sum      = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16]
                          + frame_bits[15:8];
            checksum_ok_q = (byte_sum == frame_bits[7:0]);
            done          = 1'b1;
            link_phase    = swhsr_pkg::PhIdle;
          end else begin
            link_phase = swhsr_pkg::PhBitLow;
          end
        end
      end
      default: link_phase = swhsr_pkg::PhIdle;
    endcase
    res.drive_enable = (link_phase == swhsr_pkg::PhStartLow) ||
                       (link_phase == swhsr_pkg::PhDrvHigh);
    res.drive_level  = (link_phase == swhsr_pkg::PhDrvHigh);
    res.busy_res     = (link_phase != swhsr_pkg::PhIdle);
    res.done_res     = done;
    res.humidity     = humidity_q;
    res.temperature  = temperature_q;
    res.checksum_ok  = checksum_ok_q;
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt_o = mismatch_cnt_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    swhsr_pkg::out_word_t want;
    swhsr_pkg::out_word_t got;
    swhsr_pkg::out_word_t next;
    if (!rst_ni) begin
      low_ticks      = swhsr_pkg::StartLowReset;
      high_ticks     = swhsr_pkg::ReleaseHighReset;
      one_thresh     = swhsr_pkg::OneThreshReset;
      link_phase     = swhsr_pkg::PhIdle;
      pulse_ticks    = '0;
      bits_taken     = '0;
      frame_bits     = '0;
      humidity_q     = '0;
      temperature_q  = '0;
      checksum_ok_q  = 1'b0;
      mismatch_cnt_o = 0;
      readouts_due.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        got = result_mon.data;
        if (readouts_due.size() == 0) begin
          $error("Result word arrived with no tick word outstanding.");
          mismatch_cnt_o = mismatch_cnt_o + 1;
        end else begin
          want = readouts_due.pop_front();
          compare_field("drive_enable", 16'(want.drive_enable), 16'(got.drive_enable));
          compare_field("drive_level", 16'(want.drive_level), 16'(got.drive_level));
          compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
          compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
          compare_field("humidity", want.humidity, got.humidity);
          compare_field("temperature", want.temperature, got.temperature);
          compare_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          swhsr_pkg::CfgStartLow:    low_ticks  = cfg_data_i;
          swhsr_pkg::CfgReleaseHigh: high_ticks = cfg_data_i[7:0];
          swhsr_pkg::CfgOneThresh:   one_thresh = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready) begin
        advance_link(tick_mon.data, next);
        readouts_due.push_back(next);
      end
    end
    outstanding_o = readouts_due.size();
  end

endmodule

// ===== test/single_wire_humidity_sensor_reader_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_tb
// Plays the sensor side of the single-wire link: requests readings, answers
// with response phases and forty timed pulses, and varies the timing
// registers, the pacing of both channels and the framing of the replies.
// Checking is left to the checker beside the block.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  swhsr_in_if  tick_ch ();
  swhsr_out_if result_ch ();

  int mismatches;
  int outstanding;

  int ticks_taken      = 0;
  int results_taken    = 0;
  int readings_seen    = 0;
  int readings_started = 0;
  int readings_cut     = 0;
  int settings_used    = 0;
  int hold_requests    = 0;

  int          idle_pct;
  int          stall_pct;
  int unsigned eff_low;
  int unsigned eff_high;
  int unsigned cur_thresh;

  single_wire_humidity_sensor_reader u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tick_ch),
    .out_o      (result_ch)
  );

  swhsr_reading_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .tick_mon       (tick_ch),
    .result_mon     (result_ch),
    .mismatch_cnt_o (mismatches),
    .outstanding_o  (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (tick_ch.valid && tick_ch.ready) ticks_taken <= ticks_taken + 1;
    if (result_ch.valid && result_ch.ready) begin
      results_taken <= results_taken + 1;
      if (result_ch.data.done_res) readings_seen <= readings_seen + 1;
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_tick(logic start, logic line);
    while ($urandom_range(99) < idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= '{start_request: start, line_in: line};
    do @(posedge clk_i); while (!tick_ch.ready);
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (ticks_taken != results_taken) @(posedge clk_i);
  endtask

  task automatic set_timing(int unsigned low, int unsigned high, int unsigned thresh);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= swhsr_pkg::CfgStartLow;
    cfg_data_i <= 16'(low);
    @(posedge clk_i);
    cfg_idx_i  <= swhsr_pkg::CfgReleaseHigh;
    cfg_data_i <= {8'($urandom), 8'(high)};
    @(posedge clk_i);
    cfg_idx_i  <= swhsr_pkg::CfgOneThresh;
    cfg_data_i <= {8'($urandom), 8'(thresh)};
    @(posedge clk_i);
    cfg_idx_i  <= swhsr_pkg::CfgUnused;
    cfg_data_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    eff_low    = (low == 0) ? 1 : low;
    eff_high   = (high == 0) ? 1 : high;
    cur_thresh = thresh;
    settings_used++;
  endtask

  function automatic logic [39:0] make_frame(logic [15:0] hum, logic [15:0] temp, bit good);
    logic [7:0] sum;
    sum = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
    if (!good) sum = sum + 8'($urandom_range(1, 255));
    return {hum, temp, sum};
  endfunction

  // A cut-short reading gets line noise after the host phase and is then
  // pulsed along until the block reports the frame, so the link is idle again.
  task automatic send_reading(logic [39:0] bits, int unsigned wait_high,
                              int unsigned first_pulse, bit cut_short);
    int unsigned width;
    readings_started++;
    send_tick(1'b1, 1'($urandom));
    repeat (eff_low + eff_high) send_tick(1'($urandom), 1'($urandom));
    if (cut_short) begin
      readings_cut++;
      repeat ($urandom_range(1, 30)) send_tick(1'($urandom), 1'($urandom));
      while (readings_seen < readings_started) begin
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
      end
    end else begin
      repeat (wait_high) send_tick(1'($urandom), 1'b1);
      repeat ($urandom_range(1, 2)) send_tick(1'($urandom), 1'b0);
      repeat ($urandom_range(1, 2)) send_tick(1'($urandom), 1'b1);
      repeat ($urandom_range(1, 2)) send_tick(1'($urandom), 1'b0);
      for (int k = 39; k >= 0; k--) begin
        if (first_pulse != 0 && k == 39) width = first_pulse;
        else if (bits[k]) width = cur_thresh + 1 + $urandom_range(1);
        else width = (cur_thresh == 0) ? 1 : $urandom_range(1, cur_thresh);
        repeat (width) send_tick(1'($urandom), 1'b1);
        repeat ((k == 0) ? 1 : $urandom_range(1, 2)) send_tick(1'($urandom), 1'b0);
      end
    end
    repeat ($urandom_range(3)) send_tick(1'b0, 1'($urandom));
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= swhsr_pkg::CfgStartLow;
    cfg_data_i    <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.data  <= '0;
    idle_pct      = 0;
    stall_pct     = 0;
    eff_low       = swhsr_pkg::StartLowReset;
    eff_high      = swhsr_pkg::ReleaseHighReset;
    cur_thresh    = swhsr_pkg::OneThreshReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle ticks first: the line stays released and the held values are zero.
    repeat (5) send_tick(1'b0, 1'($urandom));
    drain();
    set_timing(0, 0, 0);
    send_reading('1, 0, 0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      drain();
      set_timing(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6),
                 $urandom_range(0, 4), $urandom_range(0, 2));
      if (ph == 0) hold_requests++;
      send_reading(make_frame(16'($urandom), 16'($urandom), $urandom_range(3) != 0),
                   (ph == 1) ? 40 : $urandom_range(0, 5), (ph == 2) ? 12 : 0,
                   ph == 3);
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Summary: %0d ticks, %0d readings (%0d cut short), %0d register settings.",
             ticks_taken, readings_seen, readings_cut, settings_used);
    $display("Covered zero and short timings, a long response wait, a long first pulse, "
             , "a noisy cut-short reading, busy start requests and a long output stall "
             , "under four pacing mixes.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
